### rtl/core/clbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the camera line buffer manager.
// No dependencies; imported by the controller, datapath and top level.
package clbm_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_FRAME_START = 2'd0,
        CMD_LINE_END    = 2'd1,
        CMD_REQUEST     = 2'd2,
        CMD_RELEASE     = 2'd3
    } t_cmd;

    // Block states
    localparam logic [1:0] BS_EMPTY   = 2'd0;
    localparam logic [1:0] BS_FULL    = 2'd1;
    localparam logic [1:0] BS_READER  = 2'd2;
    localparam logic [1:0] BS_CAPTURE = 2'd3;

    // Result status codes
    localparam logic [2:0] STS_OK           = 3'd0;
    localparam logic [2:0] STS_OUT_OF_RANGE = 3'd1;
    localparam logic [2:0] STS_NOT_READY    = 3'd2;
    localparam logic [2:0] STS_LOCKED       = 3'd3;
    localparam logic [2:0] STS_NOT_MAPPED   = 3'd4;
    localparam logic [2:0] STS_NOT_LOCKED   = 3'd5;
    localparam logic [2:0] STS_NO_BLOCK     = 3'd6;

    // Configuration register indexes
    localparam logic [7:0] CFG_WINDOW_BACK  = 8'd0;
    localparam logic [7:0] CFG_WINDOW_FRONT = 8'd1;

    localparam logic [7:0] WINDOW_BACK_RST  = 8'd14;
    localparam logic [7:0] WINDOW_FRONT_RST = 8'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input transaction
        logic fix;    // close the current capture block, advance line
        logic scan;   // visit one block of the pool
        logic arm;    // allocate a capture block and post the result
        logic req;    // lock a line for a reader and post the result
        logic rel;    // release a reader lock and post the result
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/clbm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/clbm_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the line buffer manager.
// Depends on clbm_pkg; drives the datapath through t_ctl.
module clbm_ctrl
    import clbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FIX,
        S_SCAN,
        S_ARM,
        S_REQ,
        S_REL
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                case (i_sts.cmd)
                    CMD_FRAME_START: n_state = S_SCAN;
                    CMD_LINE_END:    n_state = S_FIX;
                    CMD_REQUEST:     n_state = S_REQ;
                    default:         n_state = S_REL;
                endcase
            end
            S_FIX: begin
                o_ctl.fix = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_ARM;
                end
            end
            S_ARM: begin
                if (i_sts.out_free) begin
                    o_ctl.arm = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REQ: begin
                if (i_sts.out_free) begin
                    o_ctl.req = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REL: begin
                if (i_sts.out_free) begin
                    o_ctl.rel = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/core/clbm_datapath.sv
`timescale 1ns / 1ps
// Block pool, line map, window check and result register.
// Depends on clbm_pkg and clbm_ram; commanded by clbm_ctrl.
module clbm_datapath
    import clbm_pkg::*;
#(
    parameter int NUM_LINES  = 128,
    parameter int NUM_BLOCKS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    output t_sts       o_sts,
    input  logic [1:0] i_command,
    input  logic [7:0] i_line_id,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [4:0] o_block_index,
    output logic       o_capture_armed,
    output logic [7:0] o_current_line
);

    localparam int LW = $clog2(NUM_LINES);
    localparam int BW = $clog2(NUM_BLOCKS);

    // Control state
    logic [1:0]   r_bstate [NUM_BLOCKS];
    logic [NUM_LINES-1:0] r_lvalid;
    logic [7:0]   r_lc;
    logic [7:0]   r_lreq;
    logic [7:0]   r_wb;
    logic [7:0]   r_wf;
    logic         r_ovalid;

    // Payload state
    logic [LW-1:0] r_owner [NUM_BLOCKS];
    t_cmd          r_cmd;
    logic [7:0]    r_ln;
    logic [BW-1:0] r_scan;
    logic          r_fe_ok;
    logic [BW-1:0] r_fe;
    logic          r_ff_ok;
    logic [BW-1:0] r_ff;
    logic [2:0]    r_ostatus;
    logic [4:0]    r_oblk;
    logic          r_oarmed;
    logic [7:0]    r_oline;

    logic [LW-1:0] lc_idx;
    logic [LW-1:0] ln_idx;
    logic          lc_in;
    logic          ln_in;
    logic [BW-1:0] ram_rdata;
    logic [LW-1:0] ram_raddr;

    // Scan view
    logic [1:0]    scan_st;
    logic          scan_free;
    logic [1:0]    scan_eff;

    // Window and allocation
    logic signed [10:0] w_l, w_c, w_b, w_f, w_h;
    logic          win;
    logic          arm_hit;
    logic          arm_evict;
    logic [BW-1:0] arm_blk;
    logic [2:0]    arm_status;
    logic [LW-1:0] evict_line;

    // Lookup result view
    logic [1:0]    look_st;

    assign lc_idx = r_lc[LW-1:0];
    assign ln_idx = r_ln[LW-1:0];
    assign lc_in  = ({24'd0, r_lc} < 32'(NUM_LINES));
    assign ln_in  = ({24'd0, r_ln} < 32'(NUM_LINES));

    assign ram_raddr = ((r_cmd == CMD_REQUEST) || (r_cmd == CMD_RELEASE)) ? ln_idx : lc_idx;

    clbm_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_LINES)
    ) u_line_map (
        .i_clk   (i_clk),
        .i_we    (i_ctl.arm && arm_hit),
        .i_waddr (lc_idx),
        .i_wdata (arm_blk),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Free full blocks on frame start; they count as empty for the search
    assign scan_st   = r_bstate[r_scan];
    assign scan_free = (r_cmd == CMD_FRAME_START) && (scan_st == BS_FULL);
    assign scan_eff  = scan_free ? BS_EMPTY : scan_st;

    // Circular capture window around the last requested line
    always_comb begin
        w_l = 11'(r_lreq);
        w_c = 11'(r_lc);
        w_b = 11'(r_wb);
        w_f = 11'(r_wf);
        w_h = 11'(NUM_LINES);
        win = (((w_l + w_b) > w_c) && ((w_l - w_f) < w_c)) ||
              (((w_l - w_f) < 0) && (w_c > (w_h + w_l - w_f))) ||
              (((w_l + w_b) > w_h) && (w_c < (w_b + w_l - w_h)));
    end

    // Allocate: first empty block, else evict the first full one
    always_comb begin
        arm_hit    = 1'b0;
        arm_evict  = 1'b0;
        arm_blk    = '0;
        arm_status = STS_OK;
        evict_line = r_owner[r_ff];
        if (win && lc_in && !r_lvalid[lc_idx]) begin
            if (r_fe_ok) begin
                arm_hit = 1'b1;
                arm_blk = r_fe;
            end else if (r_ff_ok) begin
                arm_hit   = 1'b1;
                arm_evict = 1'b1;
                arm_blk   = r_ff;
            end else begin
                arm_status = STS_NO_BLOCK;
            end
        end
    end

    assign look_st = r_bstate[ram_rdata];

    // Control state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= '{default: BS_EMPTY};
            r_lvalid <= '0;
            r_lc     <= '0;
            r_lreq   <= '0;
            r_wb     <= WINDOW_BACK_RST;
            r_wf     <= WINDOW_FRONT_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WINDOW_BACK) begin
                    r_wb <= i_cfg_data;
                end else if (i_cfg_index == CFG_WINDOW_FRONT) begin
                    r_wf <= i_cfg_data;
                end
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_ctl.load && (t_cmd'(i_command) == CMD_FRAME_START)) begin
                r_lc <= '0;
            end
            // Close the capture block of the finished line
            if (i_ctl.fix && lc_in) begin
                if (r_lvalid[lc_idx] && (look_st == BS_CAPTURE)) begin
                    r_bstate[ram_rdata] <= BS_FULL;
                end
                r_lc <= r_lc + 8'd1;
            end
            if (i_ctl.scan && scan_free) begin
                r_bstate[r_scan]         <= BS_EMPTY;
                r_lvalid[r_owner[r_scan]] <= 1'b0;
            end
            if (i_ctl.arm) begin
                r_ovalid <= 1'b1;
                if (arm_evict) begin
                    r_lvalid[evict_line] <= 1'b0;
                end
                if (arm_hit) begin
                    r_bstate[arm_blk] <= BS_CAPTURE;
                    r_lvalid[lc_idx]  <= 1'b1;
                end
            end
            if (i_ctl.req) begin
                r_ovalid <= 1'b1;
                r_lreq   <= r_ln;
                if (ln_in && r_lvalid[ln_idx] && (look_st == BS_FULL)) begin
                    r_bstate[ram_rdata] <= BS_READER;
                end
            end
            if (i_ctl.rel) begin
                r_ovalid <= 1'b1;
                if (ln_in && r_lvalid[ln_idx] && (look_st == BS_READER)) begin
                    r_bstate[ram_rdata] <= BS_EMPTY;
                    r_lvalid[ln_idx]    <= 1'b0;
                end
            end
        end
    end

    // Payload updates: item, scan trackers, owners, result
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= t_cmd'(i_command);
            r_ln    <= i_line_id;
            r_scan  <= '0;
            r_fe_ok <= 1'b0;
            r_ff_ok <= 1'b0;
        end
        if (i_ctl.scan) begin
            r_scan <= r_scan + 1'b1;
            if (!r_fe_ok && (scan_eff == BS_EMPTY)) begin
                r_fe_ok <= 1'b1;
                r_fe    <= r_scan;
            end
            if (!r_ff_ok && (scan_eff == BS_FULL)) begin
                r_ff_ok <= 1'b1;
                r_ff    <= r_scan;
            end
        end
        if (i_ctl.arm) begin
            r_ostatus <= arm_status;
            r_oblk    <= 5'(arm_blk);
            r_oarmed  <= arm_hit;
            r_oline   <= r_lc;
            if (arm_hit) begin
                r_owner[arm_blk] <= lc_idx;
            end
        end
        if (i_ctl.req) begin
            r_oarmed <= 1'b0;
            r_oblk   <= '0;
            r_oline  <= r_lc;
            if (!ln_in) begin
                r_ostatus <= STS_OUT_OF_RANGE;
            end else if (!r_lvalid[ln_idx]) begin
                r_ostatus <= STS_NOT_READY;
            end else if (look_st == BS_FULL) begin
                r_ostatus <= STS_OK;
                r_oblk    <= 5'(ram_rdata);
            end else if (look_st == BS_READER) begin
                r_ostatus <= STS_LOCKED;
            end else begin
                r_ostatus <= STS_NOT_READY;
            end
        end
        if (i_ctl.rel) begin
            r_oarmed <= 1'b0;
            r_oblk   <= '0;
            r_oline  <= r_lc;
            if (!ln_in) begin
                r_ostatus <= STS_OUT_OF_RANGE;
            end else if (!r_lvalid[ln_idx]) begin
                r_ostatus <= STS_NOT_MAPPED;
            end else if (look_st != BS_READER) begin
                r_ostatus <= STS_NOT_LOCKED;
            end else begin
                r_ostatus <= STS_OK;
                r_oblk    <= 5'(ram_rdata);
            end
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.scan_last = (r_scan == BW'(NUM_BLOCKS - 1));
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_block_index   = r_oblk;
    assign o_capture_armed = r_oarmed;
    assign o_current_line  = r_oline;

endmodule

### rtl/core/camera_line_buffer_manager_top.sv
`timescale 1ns / 1ps
// Camera line buffer manager: pool of line blocks with a line map.
// Depends on clbm_pkg, clbm_ctrl, clbm_datapath and clbm_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a command (frame start,
//   line end, request line, release line) and a line number. Each input
//   transaction yields exactly one result transaction on the output channel
//   (o_out_valid / i_out_ready): status, block index, capture flag and the
//   line counter after the command.
//   An accepted item is first registered; request and release then post
//   their result. Line end first closes the current capture block; line end
//   and frame start then run the block-pool scan, which visits one block per
//   cycle (it frees full blocks on frame start, finds free blocks), then post.
//   One item is in work at a time; a new item is taken the cycle after the
//   previous one has posted its result, even while that result still waits.
//   When the receiver stalls, the result register holds and the block waits
//   before posting the next result.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
//   window back size, index 1 the window front size; write while idle.
//   Reset (synchronous, active low): all blocks empty, all lines unmapped,
//   counters zero, window registers at their defaults. No clearing pass.
module camera_line_buffer_manager_top
    import clbm_pkg::*;
#(
    parameter int NUM_LINES  = 128,
    parameter int NUM_BLOCKS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_line_id,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic [4:0] o_block_index,
    output logic       o_capture_armed,
    output logic [7:0] o_current_line,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    clbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Storage and result
    clbm_datapath #(
        .NUM_LINES  (NUM_LINES),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_command       (i_command),
        .i_line_id       (i_line_id),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_block_index   (o_block_index),
        .o_capture_armed (o_capture_armed),
        .o_current_line  (o_current_line)
    );

endmodule

### bench/clbm_checker.sv
`timescale 1ns / 1ps
// Checker for the camera line buffer manager: watches the input, output and
// configuration channels, predicts each result and compares. Uses clbm_pkg.
module clbm_checker
    import clbm_pkg::*;
#(
    parameter int NUM_LINES  = 128,
    parameter int NUM_BLOCKS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_line_id,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_status,
    input  logic [4:0] i_block_index,
    input  logic       i_capture_armed,
    input  logic [7:0] i_current_line,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] blk;
        logic       armed;
        logic [7:0] line;
    } t_line_result;

    t_line_result result_fifo[$];

    logic [1:0] pool_state[NUM_BLOCKS];
    logic [7:0] pool_owner[NUM_BLOCKS];
    logic [5:0] map_blk[NUM_LINES];
    logic       map_ok[NUM_LINES];
    logic [7:0] line_cnt;
    logic [7:0] last_req;
    logic [7:0] win_back;
    logic [7:0] win_front;

    assign o_pending = result_fifo.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    function automatic bit window_hit();
        int l, c, h, b, f;
        l = int'(last_req); c = int'(line_cnt); h = NUM_LINES;
        b = int'(win_back); f = int'(win_front);
        return (((l + b > c) && (l - f < c)) || ((l - f < 0) && (c > h + l - f)) ||
                ((l + b > h) && (c < b + l - h))) && (c < h);
    endfunction

    // Allocate a capture block for the current line
    function automatic void arm_line(inout t_line_result r);
        int found;
        int o;
        found = -1;
        if (!window_hit() || map_ok[line_cnt]) return;
        for (int x = 0; x < NUM_BLOCKS && found < 0; x++)
            if (pool_state[x] == BS_EMPTY) found = x;
        for (int x = 0; x < NUM_BLOCKS && found < 0; x++)
            if (pool_state[x] == BS_FULL) begin
                found = x;
                o = int'(pool_owner[x]);
                pool_state[x] = BS_EMPTY;
                if (o < NUM_LINES && map_ok[o] && map_blk[o] == x) map_ok[o] = 1'b0;
            end
        if (found < 0) begin
            r.status = STS_NO_BLOCK;
            return;
        end
        map_blk[line_cnt] = 6'(found);
        map_ok[line_cnt] = 1'b1;
        pool_state[found] = BS_CAPTURE;
        pool_owner[found] = line_cnt;
        r.blk = 5'(found);
        r.armed = 1'b1;
    endfunction

    function automatic t_line_result predict_line_result(input t_cmd cmd, input logic [7:0] ln);
        t_line_result r;
        logic [5:0] idx;
        r = '0;
        case (cmd)
            CMD_FRAME_START: begin
                for (int l = 0; l < NUM_LINES; l++)
                    if (map_ok[l] && pool_state[map_blk[l]] == BS_FULL) begin
                        pool_state[map_blk[l]] = BS_EMPTY;
                        map_ok[l] = 1'b0;
                    end
                line_cnt = '0;
                arm_line(r);
            end
            CMD_LINE_END: begin
                if (line_cnt < NUM_LINES) begin
                    if (map_ok[line_cnt] && pool_state[map_blk[line_cnt]] == BS_CAPTURE)
                        pool_state[map_blk[line_cnt]] = BS_FULL;
                    line_cnt++;
                end
                arm_line(r);
            end
            CMD_REQUEST: begin
                last_req = ln;
                if (ln >= NUM_LINES) r.status = STS_OUT_OF_RANGE;
                else if (!map_ok[ln]) r.status = STS_NOT_READY;
                else begin
                    idx = map_blk[ln];
                    if (pool_state[idx] == BS_FULL) begin
                        pool_state[idx] = BS_READER;
                        r.blk = 5'(idx);
                    end else if (pool_state[idx] == BS_READER) r.status = STS_LOCKED;
                    else r.status = STS_NOT_READY;
                end
            end
            default: begin
                if (ln >= NUM_LINES) r.status = STS_OUT_OF_RANGE;
                else if (!map_ok[ln]) r.status = STS_NOT_MAPPED;
                else begin
                    idx = map_blk[ln];
                    if (pool_state[idx] != BS_READER) r.status = STS_NOT_LOCKED;
                    else begin
                        pool_state[idx] = BS_EMPTY;
                        map_ok[ln] = 1'b0;
                        r.blk = 5'(idx);
                    end
                end
            end
        endcase
        r.line = line_cnt;
        return r;
    endfunction

    // Track configuration, predict accepted items, compare results
    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            for (int x = 0; x < NUM_BLOCKS; x++) begin
                pool_state[x] = BS_EMPTY;
                pool_owner[x] = '0;
            end
            for (int l = 0; l < NUM_LINES; l++) begin
                map_ok[l] = 1'b0;
                map_blk[l] = '0;
            end
            line_cnt = '0;
            last_req = '0;
            win_back = WINDOW_BACK_RST;
            win_front = WINDOW_FRONT_RST;
            result_fifo.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WINDOW_BACK) win_back = i_cfg_data;
                else if (i_cfg_index == CFG_WINDOW_FRONT) win_front = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (result_fifo.size() == 0) report_mismatch("unexpected result", 1, 0);
                else begin
                    want = result_fifo.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                    if (i_block_index !== want.blk)
                        report_mismatch("block_index", int'(i_block_index), int'(want.blk));
                    if (i_capture_armed !== want.armed)
                        report_mismatch("capture_armed", int'(i_capture_armed),
                                        int'(want.armed));
                    if (i_current_line !== want.line)
                        report_mismatch("current_line", int'(i_current_line),
                                        int'(want.line));
                end
            end
            if (i_in_valid && i_in_ready)
                result_fifo.push_back(predict_line_result(t_cmd'(i_command), i_line_id));
        end
    end

endmodule

### bench/camera_line_buffer_manager_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the camera line buffer manager: drives commands and
// configuration under several idle patterns. Uses clbm_pkg and clbm_checker.
module camera_line_buffer_manager_top_tb;
    import clbm_pkg::*;

    localparam int NUM_LINES  = 128;
    localparam int NUM_BLOCKS = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [7:0] line_id;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] status;
    logic [4:0] block_index;
    logic       capture_armed;
    logic [7:0] current_line;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         cycle_count;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_off;

    camera_line_buffer_manager_top #(.NUM_LINES(NUM_LINES), .NUM_BLOCKS(NUM_BLOCKS)) uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_command(command), .i_line_id(line_id),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(status), .o_block_index(block_index),
        .o_capture_armed(capture_armed), .o_current_line(current_line),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    clbm_checker #(.NUM_LINES(NUM_LINES), .NUM_BLOCKS(NUM_BLOCKS)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_command(command), .i_line_id(line_id),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_status(status), .i_block_index(block_index),
        .i_capture_armed(capture_armed), .i_current_line(current_line),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stall, or a long hold-off when asked
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                out_ready <= 1'b0;
                hold_off = hold_off - 1;
            end else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one transaction and wait for acceptance
    task automatic send_item(input t_cmd cmd, input logic [7:0] ln);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid = 1'b1;
        command = cmd;
        line_id = ln;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Drain results, let the block settle, then write one register
    task automatic write_cfg(input logic [7:0] idx, input logic [7:0] val);
        while (pending != 0) @(negedge clk);
        repeat (NUM_BLOCKS + 8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed frames: line ends with requests and releases near
    // the capture point, plus stray commands and out-of-range lines
    task automatic random_items(input int count);
        logic [7:0] ln;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            ln = (current_line > 2) ? 8'(current_line - $urandom_range(3))
                                    : 8'($urandom_range(7));
            if ($urandom_range(9) == 0) ln = 8'($urandom);
            if (pick < 4) send_item(CMD_FRAME_START, 8'($urandom));
            else if (pick < 50) send_item(CMD_LINE_END, 8'($urandom));
            else if (pick < 75) send_item(CMD_REQUEST, ln);
            else send_item(CMD_RELEASE, ln);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_FRAME_START;
        line_id = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_BACK;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every command, range edges, lock errors, counter limit
        send_item(CMD_RELEASE, 8'd0);
        send_item(CMD_REQUEST, 8'd0);
        send_item(CMD_FRAME_START, 8'd0);
        send_item(CMD_REQUEST, 8'd0);
        send_item(CMD_LINE_END, 8'hFF);
        send_item(CMD_RELEASE, 8'd0);
        send_item(CMD_REQUEST, 8'd0);
        send_item(CMD_REQUEST, 8'd0);
        send_item(CMD_RELEASE, 8'd0);
        send_item(CMD_RELEASE, 8'd1);
        send_item(CMD_REQUEST, 8'd127);
        send_item(CMD_REQUEST, 8'd128);
        send_item(CMD_RELEASE, 8'd255);
        send_item(CMD_REQUEST, 8'd200);
        send_item(CMD_FRAME_START, 8'hAA);
        write_cfg(CFG_WINDOW_BACK, 8'd255);
        write_cfg(CFG_WINDOW_FRONT, 8'd255);
        for (int k = 0; k < 140; k++) send_item(CMD_LINE_END, 8'h55);
        send_item(CMD_FRAME_START, 8'd0);

        // Random phases with different idle patterns and window settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_WINDOW_BACK, 8'd0); write_cfg(CFG_WINDOW_FRONT, 8'd0); end
                1: begin write_cfg(CFG_WINDOW_BACK, 8'd14); write_cfg(CFG_WINDOW_FRONT, 8'd2); end
                2: begin write_cfg(CFG_WINDOW_BACK, 8'd40); write_cfg(CFG_WINDOW_FRONT, 8'd10); end
                3: begin write_cfg(CFG_WINDOW_BACK, 8'd255); write_cfg(CFG_WINDOW_FRONT, 8'd0); end
                4: begin write_cfg(CFG_WINDOW_BACK, 8'd8); write_cfg(CFG_WINDOW_FRONT, 8'd255); end
                default: begin
                    write_cfg(CFG_WINDOW_BACK, 8'($urandom));
                    write_cfg(CFG_WINDOW_FRONT, 8'($urandom));
                end
            endcase
            send_idle_pct = (ph == 1 || ph == 3) ? 80 : ((ph == 4) ? 24 : 0);
            stall_pct = (ph == 2) ? 80 : ((ph == 4) ? 24 : 0);
            if (ph == 5) hold_off = 400;
            random_items(75);
        end

        // Wait for the last results, then let the block settle
        while (pending != 0) @(negedge clk);
        repeat (NUM_BLOCKS + 8) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
